FILE: src/cse_pkg.sv
// Shared types and constants for the cubic spline evaluator.
package cse_pkg;

    localparam int DataW = 32;

    typedef struct packed {
        logic               action;
        logic [5:0]         segment_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] sample_x;
    } cse_in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] first_derivative;
        logic signed [31:0] second_derivative;
        logic               value_error;
        logic               derivative_error;
        logic               saturated;
    } cse_out_t;

    typedef enum logic [2:0] {
        REG_SEGMENT_COUNT = 3'd0,
        REG_X_FIRST       = 3'd1,
        REG_X_LAST        = 3'd2,
        REG_Y_LAST        = 3'd3,
        REG_KNOT_SPACING  = 3'd4,
        REG_EQUIDISTANT   = 3'd5,
        REG_CLAMP_ENABLE  = 3'd6
    } cse_reg_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef struct packed {
        logic       equidistant;
        logic       clamp_enable;
        logic [6:0] segment_count;
        logic signed [31:0] x_first;
        logic signed [31:0] x_last;
        logic signed [31:0] y_last;
        logic [30:0] knot_spacing;
    } cse_cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                                 output logic flag);
        flag = 1'b0;
        if (v > 64'sh7FFFFFFF) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: src/cse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/cse_queue.sv
// Two-entry word queue between the front and back parts.
module cse_queue import cse_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cse_in_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output cse_in_t out_word
);
    cse_in_t    slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_reg, rd_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        rd_next    = pop ? ~rd_reg : rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
        if (push) begin
            slot_reg[rd_reg ^ count_reg[0]] <= in_word;
        end
    end
endmodule

FILE: src/cse_back.sv
// Back part: segment table, segment lookup and polynomial evaluation.
module cse_back import cse_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cse_cfg_t cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  cse_in_t  in_word,
    output logic     out_valid,
    input  logic     out_ready,
    output cse_out_t out_word
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_RDSEG  = 9'b000001000,
        S_WAITRD = 9'b000010000,
        S_MUL    = 9'b000100000,
        S_ACC    = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_RDK    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // RAMs: knot and four coefficients
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   knot_q, a_q, b_q, c_q, d_q;

    assign ram_we    = in_valid && in_ready && (in_word.action == ACT_WRITE)
                       && ({26'd0, in_word.segment_index} < 32'(MAX_SEGMENTS));
    assign ram_waddr = AW'(in_word.segment_index);

    cse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_knot (.aclk, .we(ram_we),
        .waddr(ram_waddr), .wdata(in_word.knot_x), .raddr(ram_raddr), .rdata(knot_q));
    cse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_a (.aclk, .we(ram_we),
        .waddr(ram_waddr), .wdata(in_word.coef_a), .raddr(ram_raddr), .rdata(a_q));
    cse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_b (.aclk, .we(ram_we),
        .waddr(ram_waddr), .wdata(in_word.coef_b), .raddr(ram_raddr), .rdata(b_q));
    cse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_c (.aclk, .we(ram_we),
        .waddr(ram_waddr), .wdata(in_word.coef_c), .raddr(ram_raddr), .rdata(c_q));
    cse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_d (.aclk, .we(ram_we),
        .waddr(ram_waddr), .wdata(in_word.coef_d), .raddr(ram_raddr), .rdata(d_q));

    // Working registers
    logic signed [31:0] x_reg, x_next;
    logic [CW-1:0] n_reg, n_next, lo_reg, lo_next, cnt_reg, cnt_next;
    logic [AW-1:0] seg_reg, seg_next;
    logic [32:0]   rem_reg, rem_next;     // restoring division remainder
    logic [32:0]   quo_reg, quo_next;
    logic [32:0]   off_reg, off_next;
    logic [5:0]    bit_reg, bit_next;
    logic signed [31:0] dx_reg, dx_next, a_reg, a_next, b_reg, b_next;
    logic signed [31:0] c_reg, c_next, d_reg, d_next;
    logic signed [31:0] tv_reg, tv_next, t1_reg, t1_next, t2_reg, t2_next;
    logic signed [31:0] c0_reg, c0_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [3:0]    step_reg, step_next;
    logic          sat_reg, sat_next, first_reg, first_next;
    cse_out_t      res_reg, res_next;
    logic          ov_reg, ov_next;

    logic [CW-1:0] n_eff, mid;
    logic [30:0]   sp;
    logic [33:0]   trial;
    logic signed [63:0] mul_r;
    logic signed [31:0] mul_t, mul_x;
    logic signed [63:0] addend, sum;
    logic signed [31:0] sum_s;
    logic          sum_f;

    assign out_valid = ov_reg;
    assign out_word  = res_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;

    always_comb begin
        if (cfg.segment_count == 7'd0)
            n_eff = CW'(1);
        else if ({25'd0, cfg.segment_count} > 32'(MAX_SEGMENTS))
            n_eff = CW'(MAX_SEGMENTS);
        else
            n_eff = CW'(cfg.segment_count);
    end

    assign sp    = (cfg.knot_spacing == 31'd0) ? 31'd1 : cfg.knot_spacing;
    assign mid   = lo_reg + (cnt_reg >> 1);
    assign trial = {rem_reg, off_reg[bit_reg]} - {3'd0, sp};

    // One multiplier for all six steps, rounded to nearest (floor with half added).
    assign mul_r = (mul_t * mul_x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_comb begin
        state_next = state_reg;
        x_next = x_reg; n_next = n_reg; lo_next = lo_reg; cnt_next = cnt_reg;
        seg_next = seg_reg; rem_next = rem_reg; quo_next = quo_reg;
        off_next = off_reg; bit_next = bit_reg;
        dx_next = dx_reg; a_next = a_reg; b_next = b_reg; c_next = c_reg;
        d_next = d_reg; tv_next = tv_reg; t1_next = t1_reg; t2_next = t2_reg;
        c0_next = c0_reg; prod_next = prod_reg; step_next = step_reg;
        sat_next = sat_reg; first_next = first_reg;
        res_next = res_reg; ov_next = ov_reg;
        ram_raddr = AW'(mid);
        mul_t = t2_reg; mul_x = dx_reg; addend = '0; sum = '0;
        sum_s = '0; sum_f = 1'b0;

        if (ov_reg && out_ready) ov_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                ram_raddr = '0;
                if (in_valid && in_ready && in_word.action == ACT_EVAL) begin
                    x_next   = in_word.sample_x;
                    n_next   = n_eff;
                    sat_next = 1'b0;
                    res_next = '0;
                    if (in_word.sample_x < cfg.x_first || in_word.sample_x > cfg.x_last)
                    begin
                        res_next.derivative_error = 1'b1;
                        if (!cfg.clamp_enable) begin
                            res_next.value_error = 1'b1;
                            ov_next = 1'b1;
                        end else if (in_word.sample_x > cfg.x_first) begin
                            res_next.value = cfg.y_last;
                            ov_next = 1'b1;
                        end else begin
                            state_next = S_RDK;   // need entry 0 constant
                        end
                    end else if (in_word.sample_x == cfg.x_last) begin
                        seg_next   = AW'(n_eff - CW'(1));
                        state_next = S_RDSEG;
                    end else if (cfg.equidistant) begin
                        off_next   = 33'({in_word.sample_x[31], in_word.sample_x}
                                         - {cfg.x_first[31], cfg.x_first});
                        rem_next   = '0;
                        quo_next   = '0;
                        bit_next   = 6'd32;
                        state_next = S_DIV;
                    end else begin
                        lo_next    = '0;
                        cnt_next   = n_eff;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_RDK: begin
                ram_raddr = '0;
                state_next = S_WAITRD;
                step_next  = 4'd15;
            end
            S_SEARCH: begin
                // Issue read of knot[mid]; result arrives next cycle.
                if (cnt_reg == '0) begin
                    seg_next   = (lo_reg == '0) ? '0 : AW'(lo_reg - CW'(1));
                    state_next = S_RDSEG;
                end else begin
                    state_next = S_WAITRD;
                    step_next  = 4'd14;
                end
            end
            S_DIV: begin
                if (!trial[33]) begin
                    rem_next = trial[32:0];
                    quo_next = {quo_reg[31:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[31:0], off_reg[bit_reg]};
                    quo_next = {quo_reg[31:0], 1'b0};
                end
                if (bit_reg == 6'd0) begin
                    seg_next   = (quo_next >= 33'(n_reg)) ? AW'(n_reg - CW'(1))
                                                           : AW'(quo_next);
                    state_next = S_RDSEG;
                end else begin
                    bit_next = bit_reg - 6'd1;
                end
            end
            S_RDSEG: begin
                ram_raddr  = seg_reg;
                step_next  = 4'd0;
                state_next = S_WAITRD;
            end
            S_WAITRD: begin
                ram_raddr = (step_reg == 4'd14) ? AW'(mid) : seg_reg;
                if (step_reg == 4'd15) begin
                    res_next.value = a_q;
                    ov_next        = 1'b1;
                    state_next     = S_IDLE;
                end else if (step_reg == 4'd14) begin
                    if (!(x_reg < $signed(knot_q))) begin
                        lo_next  = mid + CW'(1);
                        cnt_next = cnt_reg - (cnt_reg >> 1) - CW'(1);
                    end else begin
                        cnt_next = cnt_reg >> 1;
                    end
                    state_next = S_SEARCH;
                end else begin
                    sum = 64'(x_reg) - 64'($signed(knot_q));
                    dx_next = sat32(sum, sum_f);
                    sat_next = sat_reg | sum_f;
                    a_next = a_q; b_next = b_q; c_next = c_q; d_next = d_q;
                    // 3d and 6d are saturated up front.
                    t1_next = sat32(64'($signed(d_q)) * 64'sd3, sum_f);
                    sat_next = sat_next | sum_f;
                    t2_next = sat32(64'($signed(d_q)) * 64'sd6, sum_f);
                    sat_next = sat_next | sum_f;
                    tv_next = d_q;
                    first_next = (x_reg == cfg.x_first) || (x_reg == cfg.x_last);
                    step_next  = 4'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // Steps: 0..2 value Horner, 3..4 first derivative, 5 second.
                case (step_reg)
                    4'd0, 4'd1, 4'd2: mul_t = tv_reg;
                    4'd3, 4'd4:       mul_t = t1_reg;
                    default:          mul_t = t2_reg;
                endcase
                mul_x     = dx_reg;
                prod_next = mul_r;
                state_next = S_ACC;
            end
            S_ACC: begin
                c0_next = c_reg;
                case (step_reg)
                    4'd0:    addend = 64'(c_reg);
                    4'd1:    addend = 64'(b_reg);
                    4'd2:    addend = 64'(a_reg);
                    4'd3:    addend = 64'(c_reg) * 64'sd2;
                    4'd4:    addend = 64'(b_reg);
                    default: addend = 64'(c_reg) * 64'sd2;
                endcase
                sum   = addend + prod_reg;
                sum_s = sat32(sum, sum_f);
                case (step_reg)
                    4'd0, 4'd1: begin
                        tv_next = sum_s;
                        if (!first_reg) sat_next = sat_reg | sum_f;
                    end
                    4'd2: begin
                        if (!first_reg) begin
                            sat_next = sat_reg | sum_f;
                            res_next.value = sum_s;
                        end
                    end
                    4'd3: begin
                        t1_next = sum_s;
                        sat_next = sat_reg | sum_f;
                    end
                    4'd4: begin
                        res_next.first_derivative = sum_s;
                        sat_next = sat_reg | sum_f;
                    end
                    default: begin
                        res_next.second_derivative = sum_s;
                        sat_next = sat_reg | sum_f;
                    end
                endcase
                if (step_reg == 4'd5) begin
                    state_next = S_OUT;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_MUL;
                end
            end
            S_OUT: begin
                if (first_reg)
                    res_next.value = (x_reg == cfg.x_first) ? c0_reg : cfg.y_last;
                if (first_reg && x_reg == cfg.x_first) begin
                    // value of entry 0 needed; fetched separately
                    ram_raddr  = '0;
                    state_next = S_WAITRD;
                    step_next  = 4'd13;
                    res_next.saturated = sat_reg;
                end else begin
                    res_next.saturated = sat_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                if (step_reg == 4'd13) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Value fetch of entry 0 at the first knot completes here.
        if (state_reg == S_WAITRD && step_reg == 4'd13) begin
            res_next.value = a_q;
            ov_next        = 1'b1;
            state_next     = S_IDLE;
            dx_next = dx_reg; a_next = a_reg; b_next = b_reg; c_next = c_reg;
            d_next = d_reg; t1_next = t1_reg; t2_next = t2_reg; tv_next = tv_reg;
            sat_next = sat_reg; first_next = first_reg; step_next = step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        x_reg <= x_next; n_reg <= n_next; lo_reg <= lo_next; cnt_reg <= cnt_next;
        seg_reg <= seg_next; rem_reg <= rem_next; quo_reg <= quo_next;
        off_reg <= off_next; bit_reg <= bit_next;
        dx_reg <= dx_next; a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        d_reg <= d_next; tv_reg <= tv_next; t1_reg <= t1_next; t2_reg <= t2_next;
        c0_reg <= c0_next; prod_reg <= prod_next; step_reg <= step_next;
        sat_reg <= sat_next; first_reg <= first_next; res_reg <= res_next;
    end
endmodule

FILE: src/cse_front.sv
// Front part: configuration registers and input word intake.
module cse_front import cse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cse_cfg_t    cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  cse_in_t     s_word,
    output logic        q_valid,
    input  logic        q_ready,
    output cse_in_t     q_word
);
    cse_cfg_t cfg_reg, cfg_next;

    assign cfg     = cfg_reg;
    assign q_valid = s_valid;
    assign s_ready = q_ready;
    // Evaluations and writes pass unchanged; the back part sorts them by action.
    assign q_word  = s_word;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cse_reg_t'(cfg_index))
                REG_SEGMENT_COUNT: cfg_next.segment_count = cfg_wdata[6:0];
                REG_X_FIRST:       cfg_next.x_first       = cfg_wdata;
                REG_X_LAST:        cfg_next.x_last        = cfg_wdata;
                REG_Y_LAST:        cfg_next.y_last        = cfg_wdata;
                REG_KNOT_SPACING:  cfg_next.knot_spacing  = cfg_wdata[30:0];
                REG_EQUIDISTANT:   cfg_next.equidistant   = cfg_wdata[0];
                REG_CLAMP_ENABLE:  cfg_next.clamp_enable  = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.segment_count <= 7'd1;
            cfg_reg.x_first       <= 32'sd0;
            cfg_reg.x_last        <= 32'sd65536;
            cfg_reg.y_last        <= 32'sd0;
            cfg_reg.knot_spacing  <= 31'd65536;
            cfg_reg.equidistant   <= 1'b0;
            cfg_reg.clamp_enable  <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

FILE: src/cubic_spline_evaluator_core.sv
// Top level of the piecewise cubic spline evaluator.
// The block is fed words on the s_ channel (valid/ready). A word with action 0
// writes one segment entry (start knot and four Q16.16 coefficients) and gives
// no result. A word with action 1 evaluates the spline at sample_x and gives one
// result word on the m_ channel: the value, the first and second derivatives,
// and the error and saturation flags.
// Input words pass through a two-word queue into the evaluation engine, which
// takes a word from the queue when it is idle.
// From there an evaluation finds its segment by binary search in search mode
// (at most log2 of the segment count plus one steps) or by the one-bit-per-cycle
// divider in division mode, then runs six multiply and add steps on the shared
// multiplier. An evaluation at the last knot takes the last segment without a
// search, and one at the first knot makes an extra read of entry 0 for its value.
// Points outside the knot range skip the search and the multiply and add steps.
// A result waits in the output register until taken; while it waits the engine
// accepts no new word and the queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) loads the register reset values and empties
// the queue; the segment table is not cleared and must be written before use.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata while idle (unenforced).
module cubic_spline_evaluator_core import cse_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  cse_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output cse_out_t    m_data
);
    cse_cfg_t cfg;
    logic     f_valid, f_ready, b_valid, b_ready;
    cse_in_t  f_word, b_word;

    cse_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata, .cfg,
        .s_valid, .s_ready, .s_word(s_data),
        .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
    );

    cse_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
    );

    cse_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .cfg,
        .in_valid(b_valid), .in_ready(b_ready), .in_word(b_word),
        .out_valid(m_valid), .out_ready(m_ready), .out_word(m_data)
    );
endmodule

FILE: bench/cse_checker.sv
`timescale 1ns / 100ps
// Checker for the cubic spline evaluator: predicts each result word and compares it.
module cse_checker import cse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  cse_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  cse_out_t    m_data,
    output int          fail_count,
    output int          pending
);

    localparam int TableDepth = 64;

    int knot_tab  [TableDepth];
    int a_tab     [TableDepth];
    int b_tab     [TableDepth];
    int c_tab     [TableDepth];
    int d_tab     [TableDepth];

    logic [6:0]  seg_count;
    int          first_knot;
    int          last_knot;
    int          last_value;
    logic [30:0] spacing;
    logic        equi_mode;
    logic        clamp_on;

    cse_out_t expected_results[$];

    assign pending = expected_results.size();

    function automatic int clamp32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // Rounded Q16.16 product, floor of (t*dx + half) / 2^16.
    function automatic longint qmul(int t, int dx);
        longint p;
        p = longint'(t) * longint'(dx) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic int locate_segment(int x, int n);
        longint off;
        longint sp;
        longint q;
        int lo;
        int cnt;
        int step;
        int mid;
        if (equi_mode) begin
            off = longint'(x) - longint'(first_knot);
            sp  = (spacing == 0) ? 1 : longint'(spacing);
            q   = off / sp;
            return (q >= n) ? n - 1 : int'(q);
        end
        lo  = 0;
        cnt = n;
        while (cnt > 0) begin
            step = cnt / 2;
            mid  = lo + step;
            if (!(x < knot_tab[mid])) begin
                lo  = mid + 1;
                cnt = cnt - step - 1;
            end else begin
                cnt = step;
            end
        end
        return (lo != 0) ? lo - 1 : 0;
    endfunction

    function automatic cse_out_t eval_spline(int x);
        cse_out_t r;
        bit sat;
        int n;
        int seg;
        int dx;
        int t;
        r   = '0;
        sat = 1'b0;
        n   = int'(seg_count);
        if (n < 1) n = 1;
        if (n > TableDepth) n = TableDepth;
        if (x < first_knot || x > last_knot) begin
            r.derivative_error = 1'b1;
            if (clamp_on)
                r.value = (x <= first_knot) ? a_tab[0] : last_value;
            else
                r.value_error = 1'b1;
        end else begin
            seg = (x == last_knot) ? n - 1 : locate_segment(x, n);
            dx  = clamp32(longint'(x) - longint'(knot_tab[seg]), sat);
            if (x == first_knot) begin
                r.value = a_tab[0];
            end else if (x == last_knot) begin
                r.value = last_value;
            end else begin
                t = clamp32(longint'(c_tab[seg]) + qmul(d_tab[seg], dx), sat);
                t = clamp32(longint'(b_tab[seg]) + qmul(t, dx), sat);
                r.value = clamp32(longint'(a_tab[seg]) + qmul(t, dx), sat);
            end
            t = clamp32(3 * longint'(d_tab[seg]), sat);
            t = clamp32(2 * longint'(c_tab[seg]) + qmul(t, dx), sat);
            r.first_derivative = clamp32(longint'(b_tab[seg]) + qmul(t, dx), sat);
            t = clamp32(6 * longint'(d_tab[seg]), sat);
            r.second_derivative = clamp32(2 * longint'(c_tab[seg]) + qmul(t, dx), sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        cse_out_t want;
        if (!aresetn) begin
            seg_count  <= 7'd1;
            first_knot <= 0;
            last_knot  <= 65536;
            last_value <= 0;
            spacing    <= 31'd65536;
            equi_mode  <= 1'b0;
            clamp_on   <= 1'b1;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cse_reg_t'(cfg_index))
                    REG_SEGMENT_COUNT: seg_count  <= cfg_wdata[6:0];
                    REG_X_FIRST:       first_knot <= cfg_wdata;
                    REG_X_LAST:        last_knot  <= cfg_wdata;
                    REG_Y_LAST:        last_value <= cfg_wdata;
                    REG_KNOT_SPACING:  spacing    <= cfg_wdata[30:0];
                    REG_EQUIDISTANT:   equi_mode  <= cfg_wdata[0];
                    REG_CLAMP_ENABLE:  clamp_on   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.action == ACT_WRITE) begin
                    knot_tab[s_data.segment_index] = s_data.knot_x;
                    a_tab[s_data.segment_index]    = s_data.coef_a;
                    b_tab[s_data.segment_index]    = s_data.coef_b;
                    c_tab[s_data.segment_index]    = s_data.coef_c;
                    d_tab[s_data.segment_index]    = s_data.coef_d;
                end else begin
                    expected_results.push_back(eval_spline(s_data.sample_x));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.value !== want.value)
                        report_mismatch("value", m_data.value, want.value);
                    if (m_data.first_derivative !== want.first_derivative)
                        report_mismatch("first_derivative", m_data.first_derivative,
                                        want.first_derivative);
                    if (m_data.second_derivative !== want.second_derivative)
                        report_mismatch("second_derivative", m_data.second_derivative,
                                        want.second_derivative);
                    if (m_data.value_error !== want.value_error)
                        report_mismatch("value_error", m_data.value_error, want.value_error);
                    if (m_data.derivative_error !== want.derivative_error)
                        report_mismatch("derivative_error", m_data.derivative_error,
                                        want.derivative_error);
                    if (m_data.saturated !== want.saturated)
                        report_mismatch("saturated", m_data.saturated, want.saturated);
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the spline evaluator bench: clock, reset, stimulus, stalls and the verdict.
module tb;
    import cse_pkg::*;

    // The run is several phases, each one a register setting. Every phase first
    // loads the whole segment table, so no evaluation ever reads an entry that was
    // never written, then sends evaluations, mixed with entry rewrites in all but the first.
    localparam int CycleLimit = 1500000;
    localparam int DrainCycles = 100;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    cse_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    cse_out_t    m_data;

    int  fail_count;
    int  pending;
    int  cycle_count;
    bit  no_gaps;
    int  stall_left;

    int  phase_first;
    longint phase_step;
    int  phase_last;

    cubic_spline_evaluator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    cse_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // The cycle counter is the only timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all while no_gaps is set.
    function automatic int gap_length();
        int pick;
        if (no_gaps) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // The result side takes words with random stalls of the same shape.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= gap_length();
        end
    end

    function automatic int rand_coef();
        if ($urandom_range(0, 9) < 7)
            return int'($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
        return int'($urandom);
    endfunction

    // Sends one word. Valid stays high from the previous word when no gap is taken.
    task automatic send_word(input cse_in_t w);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_entry(input int idx, input int knot, input int a, input int b,
                               input int c, input int d);
        cse_in_t w;
        w.action        = ACT_WRITE;
        w.segment_index = idx[5:0];
        w.knot_x        = knot;
        w.coef_a        = a;
        w.coef_b        = b;
        w.coef_c        = c;
        w.coef_d        = d;
        w.sample_x      = int'($urandom);
        send_word(w);
    endtask

    // Fields that an evaluation ignores carry random bits.
    task automatic evaluate_at(input int x);
        cse_in_t w;
        w.action        = ACT_EVAL;
        w.segment_index = 6'($urandom_range(0, 63));
        w.knot_x        = $urandom;
        w.coef_a        = $urandom;
        w.coef_b        = $urandom;
        w.coef_c        = $urandom;
        w.coef_d        = $urandom;
        w.sample_x      = x;
        send_word(w);
    endtask

    // Waits for every expected result, then lets any trailing entry write finish.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input cse_reg_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int knot_of(input int idx);
        return int'(longint'(phase_first) + longint'(idx) * phase_step);
    endfunction

    // Programs one setting and loads the table with knots on the phase grid.
    task automatic start_phase(input int n, input int first, input longint step,
                               input logic [30:0] spacing, input bit equi, input bit clamp);
        longint top;
        int n_eff;
        drain();
        phase_first = first;
        phase_step  = step;
        n_eff = (n < 1) ? 1 : ((n > 64) ? 64 : n);
        top = longint'(first) + longint'(n_eff) * step;
        phase_last = (top > 64'sd2147483647) ? 32'sh7FFFFFFF : int'(top);
        write_reg(REG_SEGMENT_COUNT, n);
        write_reg(REG_X_FIRST, first);
        write_reg(REG_X_LAST, phase_last);
        write_reg(REG_Y_LAST, rand_coef());
        write_reg(REG_KNOT_SPACING, {1'b0, spacing});
        write_reg(REG_EQUIDISTANT, 32'(equi));
        write_reg(REG_CLAMP_ENABLE, 32'(clamp));
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 64; i++)
            write_entry(i, knot_of(i), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    endtask

    function automatic int pick_sample();
        int pick;
        longint span;
        pick = $urandom_range(0, 99);
        span = longint'(phase_last) - longint'(phase_first) + 1;
        if (pick < 50)
            return int'(longint'(phase_first) + longint'({$urandom, $urandom} % span));
        if (pick < 65) return knot_of($urandom_range(0, 63));
        if (pick < 72) return phase_first;
        if (pick < 79) return phase_last;
        if (pick < 84) return phase_first - 1;
        if (pick < 89) return phase_last + 1;
        if (pick < 96) return int'($urandom);
        return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endfunction

    // Random part of a phase: mostly evaluations, some entry rewrites near the grid.
    task automatic run_random(input int count);
        int idx;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, 63);
                write_entry(idx,
                            ($urandom_range(0, 9) == 0) ? int'($urandom)
                                : knot_of(idx) + int'($urandom_range(0, 7)) - 3,
                            rand_coef(), rand_coef(), rand_coef(), rand_coef());
            end else begin
                evaluate_at(pick_sample());
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        no_gaps   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: one segment from 0 to 1.0, search mode, clamping on.
        phase_first = 0;
        phase_step  = 65536;
        phase_last  = 65536;
        for (int i = 0; i < 64; i++)
            write_entry(i, knot_of(i), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        evaluate_at(0);
        evaluate_at(65536);
        evaluate_at(32768);
        evaluate_at(-1);
        evaluate_at(65537);
        evaluate_at(32'sh7FFFFFFF);
        evaluate_at(32'sh80000000);

        // Full table in search mode, with directed saturating coefficients.
        start_phase(64, -2097152, 65536, 31'd65536, 1'b0, 1'b1);
        write_entry(5, knot_of(5), 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    32'sh7FFFFFFF);
        write_entry(6, knot_of(6), 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh80000000);
        evaluate_at(knot_of(5) + 60000);
        evaluate_at(knot_of(6) + 60000);
        evaluate_at(knot_of(5));
        evaluate_at(phase_first);
        evaluate_at(phase_last);
        evaluate_at(phase_first - 1);
        evaluate_at(phase_last + 1);
        run_random(100);

        // Division mode, clamping off, so points out of range flag an error.
        start_phase(64, -2097152, 65536, 31'd65536, 1'b1, 1'b0);
        evaluate_at(phase_first - 1);
        evaluate_at(phase_last + 1);
        run_random(100);

        start_phase(7, 1000, 196731, 31'd196731, 1'b1, 1'b1);
        run_random(70);

        start_phase(1, -65536, 131072, 31'd131072, 1'b0, 1'b0);
        run_random(50);

        // Count zero acts as one; spacing zero acts as one.
        start_phase(0, -5, 1, 31'd0, 1'b1, 1'b1);
        run_random(40);

        // Widest range, count above the table size, largest spacing.
        start_phase(127, 32'sh80000000, 64'sd67108864, 31'h7FFFFFFF, 1'b1, 1'b1);
        run_random(60);

        start_phase(33, int'($urandom_range(0, 32'h3FFFFFFF)), 1000, 31'd1000, 1'b0, 1'b1);
        run_random(60);

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
